/* hdl/tccw_pkg.sv */
// Shared types and constants for the text console cursor writer.
// No dependencies; every other file imports this package.
package tccw_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  localparam int COL_W  = 7;   // cursor column register
  localparam int ROW_W  = 5;   // cursor row register
  localparam int ADDR_W = 11;  // cell address
  localparam int POS_W  = 12;  // cursor position
  localparam int WORD_W = 16;  // cell word

  localparam logic       OP_PUT       = 1'b0;
  localparam logic       OP_ERASE     = 1'b1;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] BLANK_CODE   = 8'h20;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_code;
    logic [3:0] fore_colour;
    logic [3:0] back_colour;
  } char_item_t;

  typedef struct packed {
    logic              cell_write;
    logic [ADDR_W-1:0] cell_address;
    logic [WORD_W-1:0] cell_word;
    logic [POS_W-1:0]  cursor_position;
    logic              off_screen;
  } cell_item_t;

endpackage

/* hdl/tccw_cursor.sv */
// Cursor row/column registers and the next-cursor and cell-write logic.
// Depends on tccw_pkg.
module tccw_cursor import tccw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  char_item_t item,
  output cell_item_t result
);

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [COL_W-1:0] NUM_COLS = COL_W'(COLUMNS);
  localparam logic [ROW_W-1:0] NUM_ROWS = ROW_W'(ROWS);

  logic [COL_W-1:0] cursor_column, cursor_column_next;
  logic [ROW_W-1:0] cursor_row, cursor_row_next;

  logic [COL_W-1:0] col_inc;
  logic [ROW_W-1:0] row_inc;
  logic [ROW_W-1:0] write_row;
  logic [COL_W-1:0] write_col;
  logic             write_req;
  logic [7:0]       write_char;
  logic [POS_W-1:0] write_pos;
  logic [POS_W-1:0] new_pos;

  // row saturates at ROWS
  assign col_inc = cursor_column + 1'b1;
  assign row_inc = (cursor_row < NUM_ROWS) ? cursor_row + 1'b1 : cursor_row;

  always_comb begin
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    write_req          = 1'b0;
    write_row          = cursor_row;
    write_col          = cursor_column;
    write_char         = item.char_code;
    case (item.operation)
      OP_PUT: begin
        if (item.char_code == NEWLINE_CODE) begin
          cursor_column_next = '0;
          cursor_row_next    = row_inc;
        end else begin
          write_req = 1'b1;
          if (col_inc >= NUM_COLS) begin
            cursor_column_next = '0;
            cursor_row_next    = row_inc;
          end else begin
            cursor_column_next = col_inc;
          end
        end
      end
      OP_ERASE: begin
        write_char = BLANK_CODE;
        if (cursor_column != '0 || cursor_row != '0) begin
          write_req = 1'b1;
          if (cursor_column == '0) begin
            cursor_row_next    = cursor_row - 1'b1;
            cursor_column_next = LAST_COL;
          end else begin
            cursor_column_next = cursor_column - 1'b1;
          end
          // blank goes to the cell the cursor moved back onto
          write_row = cursor_row_next;
          write_col = cursor_column_next;
        end
      end
      default: ;
    endcase
  end

  assign write_pos = POS_W'(write_row) * POS_W'(COLUMNS) + POS_W'(write_col);
  assign new_pos   = POS_W'(cursor_row_next) * POS_W'(COLUMNS) + POS_W'(cursor_column_next);

  always_comb begin
    result                 = '0;
    result.cursor_position = new_pos;
    if (write_req) begin
      if (write_row >= NUM_ROWS) begin
        result.off_screen = 1'b1;
      end else begin
        result.cell_write   = 1'b1;
        result.cell_address = write_pos[ADDR_W-1:0];
        result.cell_word    = {item.back_colour, item.fore_colour, write_char};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
    end else if (advance) begin
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
    end
  end

endmodule

/* hdl/text_console_cursor_writer_top.sv */
// Top level of the text console cursor writer: input register, cursor unit,
// result register. Depends on tccw_pkg and tccw_cursor.
//
//  channel | valid      | stall      | payload              | direction
//  --------+------------+------------+----------------------+----------
//  char    | char_valid | char_stall | char_item (put/erase)| into block
//  cell    | cell_valid | cell_stall | cell_item (result)   | out of block
//
// One transaction in, one transaction out; a new char transaction is taken
// every cycle unless char_stall is high. The input register comes first, then
// the cursor update and address multiply-add land in the result register.
// Synchronous active-high rst clears the cursor to row 0, column 0 and drops
// both valid flags.
// A stall on cell holds the result; char_stall rises only when the input
// register is full and the result register cannot drain.
module text_console_cursor_writer_top import tccw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  char_item_t char_item,
  output logic       cell_valid,
  input  logic       cell_stall,
  output cell_item_t cell_item
);

  // input register
  logic       stage_valid;
  char_item_t stage_item;

  // result from the cursor unit for the staged transaction
  cell_item_t step_result;

  logic accept;
  logic advance;

  // the staged transaction moves on when the result register is empty or draining
  assign advance    = stage_valid && (!cell_valid || !cell_stall);
  assign char_stall = stage_valid && !advance;
  assign accept     = char_valid && !char_stall;

  tccw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (stage_item),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept || (stage_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item <= char_item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else begin
      cell_valid <= advance || (cell_valid && cell_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cell_item <= step_result;
    end
  end

endmodule

/* hdl/tccw_checker.sv */
// Port-level checks for text_console_cursor_writer_top, attached by bind.
// Depends on tccw_pkg.
module tccw_checker import tccw_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_stall,
  input char_item_t char_item,
  input logic       cell_valid,
  input logic       cell_stall,
  input cell_item_t cell_item
);

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    cell_valid && cell_stall |=> cell_valid && $stable(cell_item))
    else $error("stalled cell transaction changed");

  // backpressure on char only when the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> cell_valid && cell_stall)
    else $error("char_stall without a blocked result");

  // a stalled char transaction is held by the sender
  a_char_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> char_valid && $stable(char_item))
    else $error("stalled char transaction changed");

  // no write means zero address and word
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    cell_valid && !cell_item.cell_write |->
      cell_item.cell_address == '0 && cell_item.cell_word == '0)
    else $error("address or word set without a write");

  // reset leaves the result register empty
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !cell_valid)
    else $error("cell_valid high right after reset");

endmodule

bind text_console_cursor_writer_top tccw_checker u_tccw_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_stall (char_stall),
  .char_item  (char_item),
  .cell_valid (cell_valid),
  .cell_stall (cell_stall),
  .cell_item  (cell_item)
);

/* verif/text_console_cursor_writer_top_tb.sv */
// Self-checking testbench for text_console_cursor_writer_top: drives put/erase
// transactions, tracks the cursor on its own and compares every cell result.
// Depends on tccw_pkg and the text_console_cursor_writer_top RTL.
module text_console_cursor_writer_top_tb;
  import tccw_pkg::*;

  localparam int COLS  = COLUMNS_DEFAULT;
  localparam int NROWS = ROWS_DEFAULT;

  // Scoreboard: keeps its own cursor, turns each accepted char transaction
  // into the cell transaction the block should produce, and holds those in
  // arrival order.
  class cursor_scoreboard;
    int unsigned col;
    int unsigned row;
    int          errors;
    cell_item_t  expected_cells[$];

    function new();
      col    = 0;
      row    = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_cells.size();
    endfunction

    // Fill in the write fields, or flag the write as off screen when the
    // cursor sits on the row just past the last one.
    function cell_item_t place_cell(cell_item_t r, logic [WORD_W-1:0] word);
      cell_item_t c;
      c = r;
      if (row >= NROWS) begin
        c.off_screen = 1'b1;
      end else begin
        c.cell_write   = 1'b1;
        c.cell_address = ADDR_W'(row * COLS + col);
        c.cell_word    = word;
      end
      return c;
    endfunction

    // Cursor step for one accepted transaction; returns the expected result.
    function cell_item_t advance_cursor(char_item_t it);
      cell_item_t r;
      r = '0;
      if (it.operation == OP_PUT) begin
        if (it.char_code == NEWLINE_CODE) begin
          col = 0;
          if (row < NROWS) row++;
        end else begin
          r = place_cell(r, {it.back_colour, it.fore_colour, it.char_code});
          col++;
          if (col >= COLS) begin
            col = 0;
            if (row < NROWS) row++;
          end
        end
      end else if (col != 0 || row != 0) begin
        // erase: step back, wrapping to the last column of the row above
        if (col == 0) begin
          row--;
          col = COLS - 1;
        end else begin
          col--;
        end
        r = place_cell(r, {it.back_colour, it.fore_colour, BLANK_CODE});
      end
      r.cursor_position = POS_W'(row * COLS + col);
      return r;
    endfunction

    function void note_char(char_item_t it);
      expected_cells.push_back(advance_cursor(it));
    endfunction

    task report(string msg);
      if (errors < 40) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_cell(cell_item_t got);
      cell_item_t want;
      if (expected_cells.size() == 0) begin
        report($sformatf("cell transaction %h with nothing expected", got));
        return;
      end
      want = expected_cells.pop_front();
      if (got.cell_write !== want.cell_write)
        report($sformatf("cell_write %b, expected %b", got.cell_write, want.cell_write));
      if (got.cell_address !== want.cell_address)
        report($sformatf("cell_address %0d, expected %0d",
                         got.cell_address, want.cell_address));
      if (got.cell_word !== want.cell_word)
        report($sformatf("cell_word %h, expected %h", got.cell_word, want.cell_word));
      if (got.cursor_position !== want.cursor_position)
        report($sformatf("cursor_position %0d, expected %0d",
                         got.cursor_position, want.cursor_position));
      if (got.off_screen !== want.off_screen)
        report($sformatf("off_screen %b, expected %b", got.off_screen, want.off_screen));
    endtask
  endclass

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_stall;
  char_item_t char_item  = '0;
  logic       cell_valid;
  logic       cell_stall = 1'b0;
  cell_item_t cell_item;

  cursor_scoreboard sb = new();
  int               sent_count = 0;

  text_console_cursor_writer_top #(
    .COLUMNS(COLS),
    .ROWS   (NROWS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_item (char_item),
    .cell_valid(cell_valid),
    .cell_stall(cell_stall),
    .cell_item (cell_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic char_item_t item(logic op, logic [7:0] ch, logic [3:0] fg,
                                      logic [3:0] bg);
    char_item_t it;
    it.operation   = op;
    it.char_code   = ch;
    it.fore_colour = fg;
    it.back_colour = bg;
    return it;
  endfunction

  // Same, with random colours.
  function automatic char_item_t coloured(logic op, logic [7:0] ch);
    return item(op, ch, 4'($urandom_range(15)), 4'($urandom_range(15)));
  endfunction

  // Any byte but newline, so typed runs really advance the cursor.
  function automatic logic [7:0] printable_code();
    logic [7:0] ch;
    do ch = 8'($urandom_range(255)); while (ch == NEWLINE_CODE);
    return ch;
  endfunction

  // Offer one char transaction and return at the edge that takes it.
  // Random idle gaps come first, except over a stretch of items where the
  // sender runs back to back. valid stays high between back-to-back items.
  task automatic send(input char_item_t it);
    int gap;
    gap = 0;
    if (!(sent_count >= 300 && sent_count < 420) && $urandom_range(99) < 13)
      gap = $urandom_range(4, 1);
    if (gap != 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_item  <= it;
    do @(posedge clk); while (char_stall);
    sb.note_char(it);
    sent_count++;
  endtask

  // Sender stops until every expected cell transaction has come back.
  task automatic drain();
    char_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Result side: checks each accepted cell transaction, then picks the next
  // stall value. After 150 results it stalls in an unbroken run so the two
  // register stages fill and char_stall has to rise; results 300..419 go
  // through with no stall at all, alongside the sender's gap-free stretch.
  initial begin : cell_sink
    int taken;
    int hold;
    taken = 0;
    hold  = 0;
    forever begin
      @(posedge clk);
      if (!rst && cell_valid && !cell_stall) begin
        sb.check_cell(cell_item);
        taken++;
        if (taken == 150) hold = 80;
      end
      if (hold > 0) begin
        cell_stall <= 1'b1;
        hold--;
      end else if (taken >= 300 && taken < 420) begin
        cell_stall <= 1'b0;
      end else begin
        cell_stall <= ($urandom_range(99) < 13);
      end
    end
  end

  initial begin : char_source
    int pick;
    int len;
    bit paused;
    paused = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting from the origin.
    send(item(OP_ERASE, 8'hFF, 4'hF, 4'h0));        // erase at origin: no change
    send(item(OP_PUT, 8'h00, 4'h0, 4'h0));          // lowest code and colours
    send(item(OP_PUT, 8'hFF, 4'hF, 4'hF));          // highest code and colours
    send(item(OP_ERASE, 8'h00, 4'h5, 4'hA));        // blank at column 1
    send(item(OP_ERASE, 8'h41, 4'hA, 4'h5));        // back to origin
    send(item(OP_ERASE, 8'h0A, 4'h3, 4'hC));        // erase at origin again
    send(item(OP_PUT, NEWLINE_CODE, 4'hF, 4'hF));   // newline to row 1
    send(item(OP_ERASE, 8'h7F, 4'h1, 4'h2));        // wrap back to row 0, last column
    send(item(OP_PUT, 8'h41, 4'h7, 4'h1));          // last column, wraps to row 1
    send(item(OP_PUT, 8'h0B, 4'h8, 4'h4));          // codes next to newline
    send(item(OP_PUT, 8'h09, 4'h4, 4'h8));
    send(item(OP_PUT, BLANK_CODE, 4'hC, 4'h3));
    send(item(OP_PUT, 8'h80, 4'h2, 4'hE));
    send(item(OP_PUT, 8'h7F, 4'hE, 4'h2));
    send(item(OP_PUT, NEWLINE_CODE, 4'h0, 4'h0));   // newline from mid row
    send(item(OP_PUT, NEWLINE_CODE, 4'h9, 4'h6));   // newline at column 0
    send(item(OP_ERASE, 8'hFF, 4'h6, 4'h9));        // wrap back a row
    drain();

    // Random part: mostly typed lines, erase runs and newline bursts that
    // push the cursor down to the off-screen row and back, plus some noise.
    while (sent_count < 750) begin
      if (!paused && sent_count >= 600) begin
        drain();
        paused = 1;
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(100, 60) : $urandom_range(30);
        repeat (len) send(coloured(OP_PUT, printable_code()));
        if ($urandom_range(99) < 85) send(coloured(OP_PUT, NEWLINE_CODE));
      end else if (pick < 65) begin
        repeat ($urandom_range(40, 1)) send(coloured(OP_ERASE, 8'($urandom_range(255))));
      end else if (pick < 80) begin
        repeat ($urandom_range(12, 1)) send(coloured(OP_PUT, NEWLINE_CODE));
      end else begin
        repeat ($urandom_range(8, 1))
          send(coloured(1'($urandom_range(1)),
                        ($urandom_range(3) == 0) ? NEWLINE_CODE : 8'($urandom_range(255))));
      end
    end

    // Wait out what is still in flight, then keep the clock running for stray results.
    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("text_console_cursor_writer_top_tb OK");
    end else begin
      $display("text_console_cursor_writer_top_tb NOT OK");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin : run_limit
    #2000000;
    $display("text_console_cursor_writer_top_tb NOT OK");
    $finish;
  end

endmodule
